[sv/lowest_free_slot_id_allocator_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the lowest free slot ID allocator
// Same-cycle and next-cycle implication checks, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LOWEST_FREE_SLOT_ID_ALLOCATOR_UNIT_MACROS_SVH
`define LOWEST_FREE_SLOT_ID_ALLOCATOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define LFSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LFSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LFSA_ASSERT_SAME(label, ante, cons, msg)
`define LFSA_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

[sv/lfsa_pkg.sv]
// ----------------------------------------------------------------------------
// lfsa_pkg
// Shared widths, status codes, request codes and sequencer states of the
// lowest free slot ID allocator.
// ----------------------------------------------------------------------------
package lfsa_pkg;

    // defaults for the top level parameters
    localparam int SLOT_COUNT_DEF  = 64;
    localparam int HANDLE_BITS_DEF = 32;

    // fixed word field widths
    localparam int HANDLE_W  = 32;
    localparam int SLOT_ID_W = 6;
    localparam int STATUS_W  = 2;
    localparam int LIVE_W    = 7;
    localparam int LIVE_MAX  = 127;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ZERO      = 2'd3;

    // request codes
    localparam logic ACT_CREATE = 1'b0;
    localparam logic ACT_DELETE = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DONE
    } lfsa_state_t;

endpackage

[sv/lfsa_req_if.sv]
// ----------------------------------------------------------------------------
// lfsa_req_if
// Request channel: create or delete word with its object handle.
// ----------------------------------------------------------------------------
interface lfsa_req_if import lfsa_pkg::*; ();

    logic                valid;
    logic                ready;
    logic                action;
    logic [HANDLE_W-1:0] handle;

    modport source (output valid, output action, output handle, input ready);
    modport sink   (input valid, input action, input handle, output ready);

endinterface

[sv/lfsa_rsp_if.sv]
// ----------------------------------------------------------------------------
// lfsa_rsp_if
// Response channel: slot number, status and live count for each request.
// ----------------------------------------------------------------------------
interface lfsa_rsp_if import lfsa_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [SLOT_ID_W-1:0] slot_id;
    logic [STATUS_W-1:0]  status;
    logic [LIVE_W-1:0]    live_count;

    modport source (output valid, output slot_id, output status, output live_count,
                    input ready);
    modport sink   (input valid, input slot_id, input status, input live_count,
                    output ready);

endinterface

[sv/lfsa_slot_mem.sv]
// ----------------------------------------------------------------------------
// lfsa_slot_mem
// Slot handle store: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module lfsa_slot_mem import lfsa_pkg::*; #(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF,
    localparam int IDX_W      = $clog2(SLOT_COUNT)
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [IDX_W-1:0]       waddr,
    input  logic [HANDLE_BITS-1:0] wdata,
    input  logic                   re,
    input  logic [IDX_W-1:0]       raddr,
    output logic [HANDLE_BITS-1:0] rdata
);

    logic [HANDLE_BITS-1:0] mem [SLOT_COUNT];
    logic [HANDLE_BITS-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data registered
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/lowest_free_slot_id_allocator_unit.sv]
// ----------------------------------------------------------------------------
// lowest_free_slot_id_allocator_unit
// Slot table handing out the lowest free slot number for an object handle
// on create, and freeing the lowest slot holding a handle on delete.
//
//   channel | dir | word                                | handshake
//   --------+-----+-------------------------------------+-------------
//   req     | in  | action, handle                      | valid/ready
//   rsp     | out | slot_id, status, live_count         | valid/ready
//
// One slot is compared per cycle with a single comparator. A request scans
// from slot 0 and stops at the first hit or after the last slot; a zero
// handle skips the scan. After reset the table is cleared one slot a cycle,
// with req.ready low. A new request is taken while the previous response
// word still waits in the output register; a stalled rsp holds the next
// result in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
`include "lowest_free_slot_id_allocator_unit_macros.svh"

module lowest_free_slot_id_allocator_unit import lfsa_pkg::*; #(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    lfsa_req_if.sink     req,
    lfsa_rsp_if.source   rsp
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

    lfsa_state_t state_reg, state_next;

    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   issue_done_reg, issue_done_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   action_reg, action_next;
    logic [HANDLE_BITS-1:0] key_reg, key_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SLOT_ID_W-1:0]   out_slot_reg, out_slot_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [LIVE_W-1:0]      out_live_reg, out_live_next;

    logic                   in_accept;
    logic [HANDLE_BITS-1:0] in_key;
    logic                   issue_en;
    logic [HANDLE_BITS-1:0] rd_data;
    logic [HANDLE_BITS-1:0] cmp_target;
    logic                   cmp_hit;
    logic                   cmp_last;
    logic                   scan_finish;
    logic                   out_load;
    logic [LIVE_W-1:0]      live_sat;

    logic                   mem_we;
    logic [IDX_W-1:0]       mem_waddr;
    logic [HANDLE_BITS-1:0] mem_wdata;

    // handshakes and handle key
    assign req.ready = (state_reg == S_IDLE);
    assign in_accept = req.valid && req.ready;
    assign in_key    = HANDLE_BITS'(req.handle);

    // shared comparator: empty slot on create, matching handle on delete
    assign cmp_target  = (action_reg == ACT_DELETE) ? key_reg : '0;
    assign cmp_hit     = rd_valid_reg && (rd_data == cmp_target);
    assign cmp_last    = rd_valid_reg && (rd_idx_reg == IDX_LAST);
    assign scan_finish = (state_reg == S_SCAN) && (cmp_hit || cmp_last);
    assign issue_en    = (state_reg == S_SCAN) && !issue_done_reg && !scan_finish;

    // output register loads once the previous word has gone
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);

    // live count saturated to the word field
    assign live_sat = (32'(count_reg) > 32'(LIVE_MAX)) ? LIVE_W'(LIVE_MAX)
                                                      : LIVE_W'(count_reg);

    // slot store
    lfsa_slot_mem #(
        .SLOT_COUNT  (SLOT_COUNT),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_slot_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (issue_en),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (idx_reg == IDX_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (in_key == '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_finish)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // datapath and store control
    always_comb
    begin
        idx_next        = idx_reg;
        issue_done_next = issue_done_reg;
        rd_valid_next   = issue_en;
        rd_idx_next     = idx_reg;
        action_next     = action_reg;
        key_next        = key_reg;
        slot_next       = slot_reg;
        status_next     = status_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_slot_next   = out_slot_reg;
        out_status_next = out_status_reg;
        out_live_next   = out_live_reg;
        mem_we          = 1'b0;
        mem_waddr       = rd_idx_reg;
        mem_wdata       = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                idx_next  = idx_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    idx_next        = '0;
                    issue_done_next = 1'b0;
                    action_next     = req.action;
                    key_next        = in_key;
                    slot_next       = '0;
                    status_next     = (in_key == '0) ? STATUS_ZERO : STATUS_OK;
                end
            end
            S_SCAN:
            begin
                // issue the next read
                if (issue_en)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == IDX_LAST)
                    begin
                        issue_done_next = 1'b1;
                    end
                end
                // resolve the compared slot
                if (cmp_hit)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_idx_reg;
                    mem_wdata = (action_reg == ACT_DELETE) ? '0 : key_reg;
                    slot_next = rd_idx_reg;
                    if (action_reg == ACT_DELETE)
                    begin
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (cmp_last)
                begin
                    status_next = (action_reg == ACT_DELETE) ? STATUS_NOT_FOUND
                                                             : STATUS_FULL;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_slot_next   = (status_reg == STATUS_OK) ? SLOT_ID_W'(slot_reg) : '0;
                    out_status_next = status_reg;
                    out_live_next   = live_sat;
                end
            end
            default:
            begin
                rd_valid_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            idx_reg        <= '0;
            issue_done_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            issue_done_reg <= issue_done_next;
            rd_valid_reg   <= rd_valid_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rd_idx_reg     <= rd_idx_next;
        action_reg     <= action_next;
        key_reg        <= key_next;
        slot_reg       <= slot_next;
        status_reg     <= status_next;
        out_slot_reg   <= out_slot_next;
        out_status_reg <= out_status_next;
        out_live_reg   <= out_live_next;
    end

    // response word
    assign rsp.valid      = out_valid_reg;
    assign rsp.slot_id    = out_slot_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.live_count = out_live_reg;

    // checks
    `LFSA_ASSERT_SAME(a_count_bound, 1'b1, 32'(count_reg) <= SLOT_COUNT, "live count above table size")
    `LFSA_ASSERT_SAME(a_slot_zero_on_fail, rsp.valid && (rsp.status != STATUS_OK), rsp.slot_id == '0, "slot_id not zero on failed request")
    `LFSA_ASSERT_NEXT(a_zero_key_skips_scan, in_accept && (in_key == '0), state_reg == S_DONE, "zero handle entered the scan")
    `LFSA_ASSERT_NEXT(a_no_write_when_idle, state_reg == S_IDLE, $stable(count_reg), "live count moved outside a scan")

endmodule

[test/lowest_free_slot_id_allocator_unit_tb.sv]
// ----------------------------------------------------------------------------
// lowest_free_slot_id_allocator_unit_tb
// Drives create and delete words into the slot allocator and checks every
// response word against a shadow slot table kept in a scoreboard. A short
// directed run covers the special cases first. Random phases with changing
// create and delete mixes then fill and drain the table, with random idling
// on both channels, a long response hold-off and a full drain pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lowest_free_slot_id_allocator_unit_tb import lfsa_pkg::*; ;

    localparam int NUM_SLOTS    = SLOT_COUNT_DEF;
    localparam int RANDOM_WORDS = 850;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PCT     = 21;

    typedef struct packed {
        logic [SLOT_ID_W-1:0] slot_id;
        logic [STATUS_W-1:0]  status;
        logic [LIVE_W-1:0]    live_count;
    } reply_t;

    // shadow slot table and the replies it predicts
    class slot_table_scoreboard;
        logic [HANDLE_W-1:0] slot_handles [NUM_SLOTS];
        int                  occupied;
        reply_t              expected_replies [$];
        int                  mismatches;

        function new();
            foreach (slot_handles[i])
                slot_handles[i] = '0;
            occupied   = 0;
            mismatches = 0;
        endfunction

        // work out the reply to an accepted request word
        function void note_request(logic act, logic [HANDLE_W-1:0] h);
            reply_t r;
            int     hit_idx;
            hit_idx      = -1;
            r.slot_id    = '0;
            r.status     = STATUS_OK;
            if (h == '0)
                r.status = STATUS_ZERO;
            else if (act == ACT_CREATE)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot_handles[i] == '0)
                    begin
                        hit_idx = i;
                        break;
                    end
                end
                if (hit_idx >= 0)
                begin
                    slot_handles[hit_idx] = h;
                    occupied++;
                    r.slot_id = hit_idx[SLOT_ID_W-1:0];
                end
                else
                    r.status = STATUS_FULL;
            end
            else
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (slot_handles[i] == h)
                    begin
                        hit_idx = i;
                        break;
                    end
                end
                if (hit_idx >= 0)
                begin
                    slot_handles[hit_idx] = '0;
                    if (occupied > 0)
                        occupied--;
                    r.slot_id = hit_idx[SLOT_ID_W-1:0];
                end
                else
                    r.status = STATUS_NOT_FOUND;
            end
            r.live_count = (occupied > LIVE_MAX) ? LIVE_MAX[LIVE_W-1:0]
                                                 : occupied[LIVE_W-1:0];
            expected_replies = {expected_replies, r};
        endfunction

        // compare a response word with the oldest prediction
        function void check_reply(logic [SLOT_ID_W-1:0] slot_id,
                                  logic [STATUS_W-1:0] status,
                                  logic [LIVE_W-1:0] live_count);
            reply_t e;
            if (expected_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response word: slot %0d status %0d live %0d",
                             slot_id, status, live_count);
                return;
            end
            e = expected_replies.pop_front();
            if (e.slot_id !== slot_id || e.status !== status
                || e.live_count !== live_count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response mismatch: slot %0d/%0d status %0d/%0d live %0d/%0d",
                             e.slot_id, slot_id, e.status, status,
                             e.live_count, live_count);
            end
        endfunction

        function int pending_count();
            return expected_replies.size();
        endfunction

        // a handle currently held in some slot, zero if the table is empty
        function logic [HANDLE_W-1:0] pick_live();
            int used [$];
            foreach (slot_handles[i])
                if (slot_handles[i] != '0)
                    used = {used, i};
            if (used.size() == 0)
                return '0;
            return slot_handles[used[$urandom_range(0, used.size() - 1)]];
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_idle;
    bit   stimulus_done;

    lfsa_req_if req_if ();
    lfsa_rsp_if rsp_if ();

    slot_table_scoreboard sb = new();

    lowest_free_slot_id_allocator_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    // clock
    always #6 clk = ~clk;

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        no_idle       = 1'b0;
        stimulus_done = 1'b0;
        req_if.valid  = 1'b0;
        req_if.action = ACT_CREATE;
        req_if.handle = '0;
        rsp_if.ready  = 1'b0;
    end

    // random handle with a mix of zero, small repeats and narrow values
    function automatic logic [HANDLE_W-1:0] random_handle();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return $urandom_range(1, 12);
            3:       return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // offer one request word, with an occasional gap first
    task automatic offer_request(logic act, logic [HANDLE_W-1:0] h);
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_if.valid  <= 1'b1;
        req_if.action <= act;
        req_if.handle <= h;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.note_request(act, h);
    endtask

    // request side
    initial
    begin : sender
        int            create_pct;
        int            phase_pct [9];
        logic          act;
        logic [31:0]   h;
        phase_pct = '{95, 60, 10, 85, 30, 50, 90, 5, 70};
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        // directed: zero handles, misses, extremes, duplicates, reuse of slots
        offer_request(ACT_CREATE, 32'h0000_0000);
        offer_request(ACT_DELETE, 32'h0000_0000);
        offer_request(ACT_DELETE, 32'h0000_0005);
        offer_request(ACT_CREATE, 32'hFFFF_FFFF);
        offer_request(ACT_CREATE, 32'h0000_0001);
        offer_request(ACT_CREATE, 32'h8000_0000);
        offer_request(ACT_CREATE, 32'hFFFF_FFFF);
        offer_request(ACT_DELETE, 32'hFFFF_FFFF);
        offer_request(ACT_CREATE, 32'h1234_5678);
        offer_request(ACT_DELETE, 32'hFFFF_FFFF);
        offer_request(ACT_DELETE, 32'hFFFF_FFFF);
        offer_request(ACT_DELETE, 32'h0000_0001);
        offer_request(ACT_DELETE, 32'h5555_5555);
        offer_request(ACT_CREATE, 32'hAAAA_AAAA);
        offer_request(ACT_CREATE, 32'h5555_5555);
        offer_request(ACT_DELETE, 32'h8000_0000);
        offer_request(ACT_DELETE, 32'h1234_5678);
        offer_request(ACT_DELETE, 32'hAAAA_AAAA);
        offer_request(ACT_DELETE, 32'h5555_5555);
        offer_request(ACT_DELETE, 32'h7FFF_FFFF);

        // random phases that fill and drain the table
        for (int k = 0; k < RANDOM_WORDS; k++)
        begin
            if (k == 400)
            begin
                req_if.valid <= 1'b0;
                while (sb.pending_count() != 0)
                    @(posedge clk);
            end
            no_idle    = (k >= 500 && k < 650);
            create_pct = phase_pct[(k / 100) % 9];
            act        = ($urandom_range(0, 99) < create_pct) ? ACT_CREATE : ACT_DELETE;
            if (act == ACT_DELETE)
                h = ($urandom_range(0, 99) < 65) ? sb.pick_live() : random_handle();
            else
                h = ($urandom_range(0, 99) < 20) ? sb.pick_live() : random_handle();
            offer_request(act, h);
        end
        no_idle       = 1'b0;
        req_if.valid  <= 1'b0;
        stimulus_done = 1'b1;
    end

    // response side, with random stalls and one long hold-off
    initial
    begin : receiver
        int accepted;
        int hold_left;
        bit held;
        accepted  = 0;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
            begin
                sb.check_reply(rsp_if.slot_id, rsp_if.status, rsp_if.live_count);
                accepted++;
            end
            if (!held && accepted == 200)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (no_idle)
                rsp_if.ready <= 1'b1;
            else
                rsp_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // reset, then wait for the last response and report
    initial
    begin : main
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!stimulus_done)
            @(posedge clk);
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (NUM_SLOTS + 16) @(posedge clk);
        if (sb.pending_count() != 0)
            $display("%0d response words never arrived", sb.pending_count());
        if (sb.mismatches == 0 && sb.pending_count() == 0)
            $display("lowest_free_slot_id_allocator_unit_tb passed");
        else
            $display("lowest_free_slot_id_allocator_unit_tb failed");
        $finish;
    end

    // watchdog
    initial
    begin : watchdog
        #5ms;
        $display("lowest_free_slot_id_allocator_unit_tb failed");
        $finish;
    end

endmodule
